[rtl/core/rhtrk_pkg.sv]
// Shared types, constants and the arctangent table of the heading tracker.
`default_nettype none

package rhtrk_pkg;

	localparam int COORD_W = 20;
	localparam int GAP_W   = 21;
	localparam int ROT_W   = 33;
	localparam int ANG_W   = 25;
	localparam int HEAD_W  = 17;
	localparam int TURN_W  = 20;
	localparam int RATE_W  = 11;
	localparam int DT_W    = 16;
	localparam int LIM_W   = 19;
	localparam int ATAN_W  = 22;
	localparam int IDX_W   = 5;
	localparam int TABLE_LEN = 24;

	localparam logic [RATE_W-1:0] TURN_RATE_RST = 11'd360;

	localparam logic signed [TURN_W-1:0] DEG90  = 20'sd23040;
	localparam logic signed [TURN_W-1:0] DEG180 = 20'sd46080;
	localparam logic signed [TURN_W-1:0] DEG270 = 20'sd69120;
	localparam logic signed [TURN_W-1:0] DEG360 = 20'sd92160;

	typedef logic signed [ROT_W-1:0]  rot_t;
	typedef logic signed [TURN_W-1:0] turn_t;
	typedef logic [HEAD_W-1:0]        head_t;

	// Arctangent of 2^-i in degrees with 16 fraction bits, rounded to nearest.
	function automatic logic [ATAN_W-1:0] atan_entry(input logic [IDX_W-1:0] idx);
		logic [ATAN_W-1:0] v;
		case (idx)
			5'd0:    v = 22'd2949120;
			5'd1:    v = 22'd1740967;
			5'd2:    v = 22'd919879;
			5'd3:    v = 22'd466945;
			5'd4:    v = 22'd234379;
			5'd5:    v = 22'd117304;
			5'd6:    v = 22'd58666;
			5'd7:    v = 22'd29335;
			5'd8:    v = 22'd14668;
			5'd9:    v = 22'd7334;
			5'd10:   v = 22'd3667;
			5'd11:   v = 22'd1833;
			5'd12:   v = 22'd917;
			5'd13:   v = 22'd458;
			5'd14:   v = 22'd229;
			5'd15:   v = 22'd115;
			5'd16:   v = 22'd57;
			5'd17:   v = 22'd29;
			5'd18:   v = 22'd14;
			5'd19:   v = 22'd7;
			5'd20:   v = 22'd4;
			5'd21:   v = 22'd2;
			5'd22:   v = 22'd1;
			default: v = 22'd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

[rtl/core/rhtrk_cordic.sv]
// Iterative CORDIC vectoring unit that returns the angle of a vector in 1/256 degree.
`default_nettype none

module rhtrk_cordic #(
	parameter int STEPS = 16
) (
	input  wire                                       clk,
	input  wire                                       arst_n,
	input  wire                                       start,
	input  wire  signed [rhtrk_pkg::ROT_W-1:0]        x_init,
	input  wire  signed [rhtrk_pkg::ROT_W-1:0]        y_init,
	output logic                                      done,
	output logic signed [rhtrk_pkg::HEAD_W-1:0]       angle
);

	localparam logic [rhtrk_pkg::IDX_W-1:0] LAST_IDX = rhtrk_pkg::IDX_W'(STEPS - 1);

	rhtrk_pkg::rot_t                         x_q;
	rhtrk_pkg::rot_t                         y_q;
	logic signed [rhtrk_pkg::ANG_W-1:0]      z_q;
	logic [rhtrk_pkg::IDX_W-1:0]             cnt_q;
	logic                                    busy_q;
	logic                                    done_q;

	rhtrk_pkg::rot_t                         xs;
	rhtrk_pkg::rot_t                         ys;
	logic signed [rhtrk_pkg::ANG_W-1:0]      step_ang;
	logic signed [rhtrk_pkg::ANG_W-1:0]      z_rnd;

	assign xs       = x_q >>> cnt_q;
	assign ys       = y_q >>> cnt_q;
	assign step_ang = $signed({3'b000, rhtrk_pkg::atan_entry(cnt_q)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_IDX) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x_init;
			y_q <= y_init;
			z_q <= '0;
		end else if (busy_q) begin
			if (!y_q[rhtrk_pkg::ROT_W-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + step_ang;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - step_ang;
			end
		end
	end

	assign z_rnd = z_q + 25'sd128;
	assign angle = z_rnd[rhtrk_pkg::ANG_W-1:8];
	assign done  = done_q;

endmodule

`default_nettype wire

[rtl/core/rate_limited_heading_tracker.sv]
// Top level of the rate-limited heading tracker.
// Each input passes the states setup, rotate (CORDIC, capped at 24 steps), turn, limit and done in order.
// A point straight above or below skips the rotate state and coincident points go from setup straight to done.
// One item is in work at a time, so no new input transaction is taken until the last one has left the done state.
// A new input is taken while a finished result still waits on the output register.
// Reset clears the heading to zero and sets turn_rate to 360 degrees per second.
`default_nettype none

module rate_limited_heading_tracker #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [10:0] cfg_wdata,
	input  wire         s_tvalid,
	output logic        s_tready,
	// target_x[19:0], target_y[39:20], own_x[59:40], own_y[79:60], delta_time[95:80]
	input  wire  [95:0] s_tdata,
	output logic        m_tvalid,
	input  wire         m_tready,
	// heading_out[16:0], zero fill [23:17]
	output logic [23:0] m_tdata,
	// coincident[0]
	output logic [0:0]  m_tuser
);

	localparam int EFF_STEPS = (CORDIC_STEPS > rhtrk_pkg::TABLE_LEN) ?
		rhtrk_pkg::TABLE_LEN : CORDIC_STEPS;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_ROTATE,
		ST_TURN,
		ST_LIMIT,
		ST_DONE
	} state_t;

	state_t                                  state_q;
	logic [rhtrk_pkg::RATE_W-1:0]            turn_rate_q;
	rhtrk_pkg::head_t                        heading_q;
	logic signed [rhtrk_pkg::GAP_W-1:0]      dx_q;
	logic signed [rhtrk_pkg::GAP_W-1:0]      dy_q;
	logic [rhtrk_pkg::DT_W-1:0]              dt_q;
	logic [rhtrk_pkg::LIM_W-1:0]             limit_q;
	rhtrk_pkg::turn_t                        target_q;
	rhtrk_pkg::turn_t                        diff_q;
	logic                                    coinc_q;
	logic                                    m_valid_q;
	rhtrk_pkg::head_t                        out_heading_q;
	logic                                    out_coinc_q;

	logic signed [rhtrk_pkg::GAP_W-1:0]      dx_in;
	logic signed [rhtrk_pkg::GAP_W-1:0]      dy_in;
	logic                                    neg_x;
	logic signed [rhtrk_pkg::GAP_W-1:0]      nx;
	logic signed [rhtrk_pkg::GAP_W-1:0]      ny;
	rhtrk_pkg::rot_t                         x_init;
	rhtrk_pkg::rot_t                         y_init;
	logic                                    gap_zero;
	logic                                    cordic_start;
	logic                                    cordic_done;
	logic signed [rhtrk_pkg::HEAD_W-1:0]     cordic_angle;
	logic [rhtrk_pkg::RATE_W+rhtrk_pkg::DT_W-1:0] limit_prod;
	rhtrk_pkg::turn_t                        diff_raw;
	rhtrk_pkg::turn_t                        diff_wrap;
	rhtrk_pkg::turn_t                        lim_pos;
	rhtrk_pkg::turn_t                        lim_neg;
	rhtrk_pkg::turn_t                        diff_clamp;
	rhtrk_pkg::turn_t                        head_sum;
	rhtrk_pkg::turn_t                        head_wrap;
	rhtrk_pkg::turn_t                        head_ext;

	assign dx_in = $signed({s_tdata[19], s_tdata[19:0]}) - $signed({s_tdata[59], s_tdata[59:40]});
	assign dy_in = $signed({s_tdata[39], s_tdata[39:20]}) - $signed({s_tdata[79], s_tdata[79:60]});

	assign neg_x    = dx_q[rhtrk_pkg::GAP_W-1];
	assign nx       = neg_x ? -dx_q : dx_q;
	assign ny       = neg_x ? -dy_q : dy_q;
	assign x_init   = $signed({{2{nx[rhtrk_pkg::GAP_W-1]}}, nx, 10'b0});
	assign y_init   = $signed({{2{ny[rhtrk_pkg::GAP_W-1]}}, ny, 10'b0});
	assign gap_zero = (dx_q == '0) && (dy_q == '0);

	assign cordic_start = (state_q == ST_SETUP) && (dx_q != '0);

	rhtrk_cordic #(
		.STEPS(EFF_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cordic_start),
		.x_init (x_init),
		.y_init (y_init),
		.done   (cordic_done),
		.angle  (cordic_angle)
	);

	assign limit_prod = turn_rate_q * dt_q;
	assign head_ext   = $signed({3'b000, heading_q});

	always_comb begin
		diff_raw = target_q - head_ext;
		if (diff_raw > rhtrk_pkg::DEG180) begin
			diff_wrap = diff_raw - rhtrk_pkg::DEG360;
		end else if (diff_raw < -rhtrk_pkg::DEG180) begin
			diff_wrap = diff_raw + rhtrk_pkg::DEG360;
		end else begin
			diff_wrap = diff_raw;
		end
	end

	always_comb begin
		lim_pos = $signed({1'b0, limit_q});
		lim_neg = -lim_pos;
		if (diff_q > lim_pos) begin
			diff_clamp = lim_pos;
		end else if (diff_q < lim_neg) begin
			diff_clamp = lim_neg;
		end else begin
			diff_clamp = diff_q;
		end
		head_sum = head_ext + diff_clamp;
		if (head_sum < 0) begin
			head_wrap = head_sum + rhtrk_pkg::DEG360;
		end else if (head_sum >= rhtrk_pkg::DEG360) begin
			head_wrap = head_sum - rhtrk_pkg::DEG360;
		end else begin
			head_wrap = head_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turn_rate_q <= rhtrk_pkg::TURN_RATE_RST;
		end else if (cfg_we) begin
			turn_rate_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			heading_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && (!m_valid_q || m_tready)) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					if (gap_zero) begin
						state_q <= ST_DONE;
					end else if (dx_q == '0) begin
						state_q <= ST_TURN;
					end else begin
						state_q <= ST_ROTATE;
					end
				end
				ST_ROTATE: begin
					if (cordic_done) begin
						state_q <= ST_TURN;
					end
				end
				ST_TURN: begin
					state_q <= ST_LIMIT;
				end
				ST_LIMIT: begin
					heading_q <= head_wrap[rhtrk_pkg::HEAD_W-1:0];
					state_q   <= ST_DONE;
				end
				ST_DONE: begin
					if (!m_valid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			dx_q <= dx_in;
			dy_q <= dy_in;
			dt_q <= s_tdata[95:80];
		end
		if (state_q == ST_SETUP) begin
			limit_q <= limit_prod[rhtrk_pkg::RATE_W+rhtrk_pkg::DT_W-1:8];
			coinc_q <= gap_zero;
			if (dy_q > 0) begin
				target_q <= rhtrk_pkg::DEG90;
			end else begin
				target_q <= rhtrk_pkg::DEG270;
			end
		end
		if (state_q == ST_ROTATE && cordic_done) begin
			target_q <= rhtrk_pkg::turn_t'(cordic_angle) + (neg_x ? rhtrk_pkg::DEG180 : '0);
		end
		if (state_q == ST_TURN) begin
			diff_q <= diff_wrap;
		end
		if (state_q == ST_DONE && (!m_valid_q || m_tready)) begin
			out_heading_q <= heading_q;
			out_coinc_q   <= coinc_q;
		end
	end

	assign s_tready   = (state_q == ST_IDLE);
	assign m_tvalid   = m_valid_q;
	assign m_tdata    = {7'b0, out_heading_q};
	assign m_tuser[0] = out_coinc_q;

endmodule

`default_nettype wire

[rtl/core/rhtrk_checker.sv]
// Port-level assertions for the heading tracker and the bind that attaches them.
`default_nettype none

module rhtrk_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [23:0] m_tdata,
	input wire [0:0]  m_tuser
);

	// A result that is not taken stays on the port unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// The heading is always inside one turn.
	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[16:0] < 17'd92160) && (m_tdata[23:17] == 7'd0))
		else $error("heading out of range");

	// Only one item is in work at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while busy");

	// A result never appears in the cycle right after an input transaction.
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result too early");

endmodule

bind rate_limited_heading_tracker rhtrk_checker u_rhtrk_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

[tb/rate_limited_heading_tracker_tb.sv]
// Self-checking testbench of the rate-limited heading tracker with a scoreboard class.
`default_nettype none

module rate_limited_heading_tracker_tb;

	localparam int          COORD_W        = rhtrk_pkg::COORD_W;
	localparam int          DT_W           = rhtrk_pkg::DT_W;
	localparam int          RATE_W         = rhtrk_pkg::RATE_W;
	localparam int          HEAD_W         = rhtrk_pkg::HEAD_W;
	localparam int          TABLE_LEN      = rhtrk_pkg::TABLE_LEN;
	localparam int          CORDIC_STEPS   = 16;
	localparam int          SETTLE_CYCLES  = CORDIC_STEPS + 8;
	localparam int          HOLD_CYCLES    = 300;
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int          PHASE_ITEMS    = 240;

	typedef struct {
		logic signed [COORD_W-1:0] target_x;
		logic signed [COORD_W-1:0] target_y;
		logic signed [COORD_W-1:0] own_x;
		logic signed [COORD_W-1:0] own_y;
		logic [DT_W-1:0]           delta_time;
	} track_item_t;

	typedef struct {
		rhtrk_pkg::head_t heading;
		logic             coincident;
	} heading_res_t;

	class heading_scoreboard;
		rhtrk_pkg::head_t   heading;
		logic [RATE_W-1:0]  turn_rate;
		heading_res_t       expected_q[$];
		longint             atan_q16[TABLE_LEN];
		int unsigned        mismatches;

		function new();
			heading    = '0;
			turn_rate  = rhtrk_pkg::TURN_RATE_RST;
			mismatches = 0;
			atan_q16   = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
				14668, 7334, 3667, 1833, 917, 458, 229, 115,
				57, 29, 14, 7, 4, 2, 1, 0};
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("%s", msg);
		endfunction

		// Vectoring pass for x > 0; returns the angle in 1/256 degree.
		function longint bearing_q8(longint x, longint y);
			longint z;
			longint xs;
			longint ys;
			int     steps;
			z = 0;
			steps = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
			for (int i = 0; i < steps; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y >= 0) begin
					x = x + ys;
					y = y - xs;
					z = z + atan_q16[i];
				end else begin
					x = x - ys;
					y = y + xs;
					z = z - atan_q16[i];
				end
			end
			return (z + 128) >>> 8;
		endfunction

		function void note_input(track_item_t it);
			longint       dx;
			longint       dy;
			longint       bearing;
			longint       turn;
			longint       max_turn;
			longint       next_h;
			heading_res_t res;
			dx = longint'(it.target_x) - longint'(it.own_x);
			dy = longint'(it.target_y) - longint'(it.own_y);
			if (dx == 0 && dy == 0) begin
				res.heading    = heading;
				res.coincident = 1'b1;
				expected_q.push_back(res);
				return;
			end
			if (dx == 0)
				bearing = (dy > 0) ? longint'(rhtrk_pkg::DEG90) : longint'(rhtrk_pkg::DEG270);
			else if (dx < 0)
				bearing = longint'(rhtrk_pkg::DEG180) + bearing_q8(-dx * 1024, -dy * 1024);
			else
				bearing = bearing_q8(dx * 1024, dy * 1024);
			turn = bearing - longint'(heading);
			if (turn > longint'(rhtrk_pkg::DEG180))
				turn = turn - longint'(rhtrk_pkg::DEG360);
			if (turn < -longint'(rhtrk_pkg::DEG180))
				turn = turn + longint'(rhtrk_pkg::DEG360);
			max_turn = (longint'(turn_rate) * longint'(it.delta_time)) >>> 8;
			if (turn > max_turn)
				turn = max_turn;
			if (turn < -max_turn)
				turn = -max_turn;
			next_h = longint'(heading) + turn;
			if (next_h < 0)
				next_h = next_h + longint'(rhtrk_pkg::DEG360);
			if (next_h >= longint'(rhtrk_pkg::DEG360))
				next_h = next_h - longint'(rhtrk_pkg::DEG360);
			heading        = rhtrk_pkg::head_t'(next_h);
			res.heading    = heading;
			res.coincident = 1'b0;
			expected_q.push_back(res);
		endfunction

		function void check_result(rhtrk_pkg::head_t got_heading, logic got_coincident);
			heading_res_t want;
			if (expected_q.size() == 0) begin
				flag($sformatf("Unexpected result: heading_out %0d, coincident %0b.",
					got_heading, got_coincident));
				return;
			end
			want = expected_q.pop_front();
			if (got_heading !== want.heading)
				flag($sformatf("heading_out mismatch: expected %0d, got %0d.",
					want.heading, got_heading));
			if (got_coincident !== want.coincident)
				flag($sformatf("coincident mismatch: expected %0b, got %0b.",
					want.coincident, got_coincident));
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void close_out();
			if (expected_q.size() != 0)
				flag($sformatf("%0d results never arrived.", expected_q.size()));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [10:0] cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [95:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic [0:0]  m_tuser;

	heading_scoreboard sb;
	bit                hold_req = 1'b0;
	int unsigned       calm_left = 0;
	int unsigned       quiet_cycles = 0;

	rate_limited_heading_tracker #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata[HEAD_W-1:0], m_tuser[0]);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : receiver
		int unsigned run_left;
		int unsigned hold_left;
		int unsigned r;
		logic        ready_now;
		run_left  = 0;
		hold_left = 0;
		ready_now = 1'b0;
		m_tready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				if (run_left == 0) begin
					r = $urandom_range(0, 99);
					if (r < 50) begin
						ready_now = 1'b1;
						run_left  = $urandom_range(1, 30);
					end else begin
						ready_now = 1'b0;
						if (r < 88)
							run_left = $urandom_range(1, 3);
						else if (r < 97)
							run_left = $urandom_range(4, 12);
						else
							run_left = $urandom_range(20, 80);
					end
				end
				run_left--;
				m_tready <= ready_now;
			end
		end
	end

	function automatic track_item_t make_item(int tx, int ty, int ox, int oy, int dt);
		track_item_t it;
		it.target_x   = COORD_W'(tx);
		it.target_y   = COORD_W'(ty);
		it.own_x      = COORD_W'(ox);
		it.own_y      = COORD_W'(oy);
		it.delta_time = DT_W'(dt);
		return it;
	endfunction

	function automatic logic signed [COORD_W-1:0] pick_coord();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return COORD_W'($urandom);
		else if (r == 7)
			return COORD_W'(-524288);
		else if (r == 8)
			return COORD_W'(524287);
		else
			return COORD_W'(int'($urandom_range(0, 32)) - 16);
	endfunction

	function automatic int pick_offset();
		int unsigned w;
		int          m;
		w = $urandom_range(0, 19);
		m = int'($urandom_range(0, (32'd1 << w) - 1));
		return $urandom_range(0, 1) ? -m : m;
	endfunction

	function automatic logic signed [COORD_W-1:0] nudge(logic signed [COORD_W-1:0] base,
			int off);
		int t;
		t = int'(base) + off;
		if (t > 524287 || t < -524288)
			t = int'(base) - off;
		return COORD_W'(t);
	endfunction

	function automatic track_item_t random_item();
		track_item_t it;
		int unsigned kind;
		int unsigned r;
		kind = $urandom_range(0, 99);
		it.own_x = pick_coord();
		it.own_y = pick_coord();
		if (kind < 30) begin
			it.target_x = pick_coord();
			it.target_y = pick_coord();
		end else if (kind < 75) begin
			it.target_x = nudge(it.own_x, pick_offset());
			it.target_y = nudge(it.own_y, pick_offset());
		end else if (kind < 85) begin
			it.target_x = it.own_x;
			it.target_y = it.own_y;
		end else if (kind < 93) begin
			it.target_x = it.own_x;
			it.target_y = nudge(it.own_y, pick_offset());
		end else begin
			it.target_x = nudge(it.own_x, pick_offset());
			it.target_y = it.own_y;
		end
		r = $urandom_range(0, 99);
		if (r < 10)
			it.delta_time = '0;
		else if (r < 20)
			it.delta_time = '1;
		else if (r < 55)
			it.delta_time = DT_W'($urandom_range(0, 1023));
		else
			it.delta_time = DT_W'($urandom);
		return it;
	endfunction

	task automatic send_item(input track_item_t it);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {it.delta_time, it.own_y, it.own_x, it.target_y, it.target_x};
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_input(it);
	endtask

	task automatic sender_gap();
		int unsigned r;
		int unsigned n;
		if (calm_left > 0) begin
			calm_left--;
			return;
		end
		r = $urandom_range(0, 99);
		if (r < 5)
			calm_left = $urandom_range(10, 40);
		if (r < 55)
			n = 0;
		else if (r < 88)
			n = $urandom_range(1, 3);
		else if (r < 97)
			n = $urandom_range(4, 12);
		else
			n = $urandom_range(20, 60);
		if (n == 0)
			return;
		@(negedge clk);
		s_tvalid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_turn_rate(input logic [RATE_W-1:0] rate);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= rate;
		@(negedge clk);
		cfg_we    <= 1'b0;
		sb.turn_rate = rate;
	endtask

	initial begin : stimulus
		track_item_t       directed_q[$];
		logic [RATE_W-1:0] rates[8];
		sb        = new();
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// The first items walk the heading through both half-turn and wrap cases.
		directed_q.push_back(make_item(0, 0, 0, 0, 65535));
		directed_q.push_back(make_item(0, 16, 0, 0, 65535));
		directed_q.push_back(make_item(0, -16, 0, 0, 65535));
		directed_q.push_back(make_item(16, 0, 0, 0, 65535));
		directed_q.push_back(make_item(-16, 0, 0, 0, 65535));
		directed_q.push_back(make_item(16, 0, 0, 0, 65535));
		directed_q.push_back(make_item(0, -16, 0, 0, 65535));
		directed_q.push_back(make_item(524287, 524287, -524288, -524288, 65535));
		directed_q.push_back(make_item(-524288, -524288, 524287, 524287, 65535));
		directed_q.push_back(make_item(-524288, 524287, 524287, -524288, 65535));
		directed_q.push_back(make_item(524287, -524288, -524288, 524287, 65535));
		directed_q.push_back(make_item(1, -1, 0, 0, 65535));
		directed_q.push_back(make_item(100, 200, 5, 5, 0));
		directed_q.push_back(make_item(100, 200, 5, 5, 1));
		directed_q.push_back(make_item(100, 200, 5, 5, 256));
		directed_q.push_back(make_item(-524288, 524287, -524288, 524287, 65535));
		directed_q.push_back(make_item(1, 524287, 0, -524288, 65535));
		directed_q.push_back(make_item(-7, 3, -7, 3, 0));
		directed_q.push_back(make_item(-1, 0, 0, 0, 65535));
		foreach (directed_q[i]) begin
			send_item(directed_q[i]);
			sender_gap();
		end

		rates = '{11'd1440, 11'd0, 11'd2047, 11'd1, 11'd720, RATE_W'($urandom), 11'd90,
			rhtrk_pkg::TURN_RATE_RST};
		foreach (rates[p]) begin
			write_turn_rate(rates[p]);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 2 && i == 100) begin
					hold_req = 1'b1;
					repeat (12) send_item(random_item());
				end
				if (p == 4 && i == 120)
					wait_drained();
				send_item(random_item());
				sender_gap();
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES + 16) @(posedge clk);
		sb.close_out();
		if (sb.mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire

[files.f]
rtl/core/rhtrk_pkg.sv
rtl/core/rhtrk_cordic.sv
rtl/core/rate_limited_heading_tracker.sv
rtl/core/rhtrk_checker.sv
tb/rate_limited_heading_tracker_tb.sv
